// ----- rtl/core/length_prefixed_message_ring_assert.svh -----
// Assertion macros shared by the message ring RTL.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define LPMR_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error(msg);

// Condition holds in the cycle after the trigger.
`define LPMR_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ----- rtl/core/lpmr_pkg.sv -----
// Constants, codes and types of the length-prefixed message ring.
package lpmr_pkg;

	localparam int RING_BYTES    = 4096;
	localparam int HEADER_BYTES  = 4;
	localparam int RESERVE_BYTES = 1;

	localparam int RING_AW  = $clog2(RING_BYTES);
	localparam int HDR_BITS = 8 * HEADER_BYTES;
	localparam int LEN_W    = 13;
	localparam int BYTE_W   = 8;
	localparam int STAT_W   = 3;
	localparam int OP_W     = 2;

	// Width for free-space sums and for header compares.
	localparam int CW  = ((RING_AW > LEN_W) ? RING_AW : LEN_W) + 3;
	localparam int BW  = (HDR_BITS > CW) ? HDR_BITS : CW;
	localparam int HCW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = OP_W;
	localparam int M_TDATA_W = 24;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND_START = 2'd0,
		OP_APPEND_BYTE  = 2'd1,
		OP_POP_START    = 2'd2,
		OP_READ_BYTE    = 2'd3
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 3'd0,
		STAT_NO_ROOM   = 3'd1,
		STAT_NO_MSG    = 3'd2,
		STAT_CAP_SMALL = 3'd3,
		STAT_PROTO     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR_WR,
		S_HDR_RD,
		S_HDR_CHK,
		S_RD_WAIT
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_out;
		logic [LEN_W-1:0]  body_len;
		status_t           status;
		logic              last;
	} result_t;

	function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
		return (p == RING_AW'(RING_BYTES - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// ----- rtl/core/length_prefixed_message_ring.sv -----
// Byte ring holding length-prefixed messages, with append and pop streams.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-----------------------------------------
//  s       | in        | s_tvalid/s_tready | tuser: opcode; tdata: length, data_in
//  m       | out       | m_tvalid/m_tready | tdata: status, body_len, data_out; tlast
//
// append_byte, read errors and refused starts end in S_IDLE; read_byte waits in S_RD_WAIT, as
// the ring memory has a registered read port. append_start moves through S_HDR_WR, pop_start
// via S_HDR_RD and S_HDR_CHK, one header byte per cycle through the single write or read port.
// Reset clears the write and read pointers, the remaining-byte counters and handshake state;
// the ring memory is not cleared. Results pass through a two-word buffer, so input is refused
// only while a result is pending behind an unread output word or while an item is still at work.
module length_prefixed_message_ring (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [12:0] length, [20:13] data_in, [23:21] zero
	input  logic [lpmr_pkg::S_TDATA_W-1:0]    s_tdata,
	// [1:0] opcode
	input  logic [lpmr_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [2:0] status, [15:3] body_len, [23:16] data_out
	output logic [lpmr_pkg::M_TDATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);
	import lpmr_pkg::*;

	// Ring memory and its registered read port.
	logic [BYTE_W-1:0] ring_q [RING_BYTES];
	logic [BYTE_W-1:0] rdata_q;

	state_t              state_q, state_d;
	logic [RING_AW-1:0]  wp_q, wp_d;
	logic [RING_AW-1:0]  rp_q, rp_d;
	logic [LEN_W-1:0]    arem_q, arem_d;
	logic [LEN_W-1:0]    rrem_q, rrem_d;
	logic [HCW-1:0]      hcnt_q, hcnt_d;
	logic [HDR_BITS-1:0] hdr_sh_q, hdr_sh_d;
	logic [HDR_BITS-1:0] body_q, body_d;
	logic [RING_AW-1:0]  raddr_q, raddr_d;
	logic [LEN_W-1:0]    cap_q, cap_d;
	logic                rlast_q, rlast_d;

	result_t m_res_q, p_res_q;
	logic    m_valid_q, p_valid_q;

	opcode_t           in_op;
	logic [LEN_W-1:0]  in_len;
	logic [BYTE_W-1:0] in_byte;
	logic              accept;

	logic              mem_we, mem_re;
	logic [RING_AW-1:0] mem_waddr, mem_raddr;
	logic [BYTE_W-1:0] mem_wdata;

	logic    push;
	result_t push_res;

	logic [RING_AW:0]  used_raw;
	logic [CW-1:0]     used_w;
	logic [CW-1:0]     need_w;
	logic              hdr_fits;
	logic [BW-1:0]     body_w, avail_w, cap_w;

	assign in_op   = opcode_t'(s_tuser[OP_W-1:0]);
	assign in_len  = s_tdata[LEN_W-1:0];
	assign in_byte = s_tdata[LEN_W+BYTE_W-1:LEN_W];

	assign s_tready = (state_q == S_IDLE) && !p_valid_q;
	assign accept   = s_tvalid && s_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {m_res_q.data_out, m_res_q.body_len, m_res_q.status};
	assign m_tlast  = m_res_q.last;

	// Bytes between read and write pointer, modulo the ring size.
	always_comb begin
		if (wp_q >= rp_q) begin
			used_raw = {1'b0, wp_q} - {1'b0, rp_q};
		end else begin
			used_raw = ({1'b0, wp_q} + (RING_AW + 1)'(RING_BYTES)) - {1'b0, rp_q};
		end
	end
	assign used_w = CW'(used_raw);

	// The append needs used + reserve + header + length to stay within the ring.
	assign need_w   = used_w + CW'(RESERVE_BYTES) + CW'(HEADER_BYTES) + CW'(in_len);
	assign hdr_fits = ((BW'(in_len) >> HDR_BITS) == '0);

	assign body_w  = BW'(body_q);
	assign avail_w = BW'(used_w - CW'(HEADER_BYTES));
	assign cap_w   = BW'(cap_q);

	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		rp_d      = rp_q;
		arem_d    = arem_q;
		rrem_d    = rrem_q;
		hcnt_d    = hcnt_q;
		hdr_sh_d  = hdr_sh_q;
		body_d    = body_q;
		raddr_d   = raddr_q;
		cap_d     = cap_q;
		rlast_d   = rlast_q;
		mem_we    = 1'b0;
		mem_waddr = wp_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = rp_q;
		push      = 1'b0;
		push_res  = '{data_out: '0, body_len: '0, status: STAT_OK, last: 1'b0};

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (in_op)
						OP_APPEND_START: begin
							push = 1'b1;
							if (arem_q != '0) begin
								push_res.status = STAT_PROTO;
							end else if (!hdr_fits || (need_w > CW'(RING_BYTES))) begin
								push_res.status = STAT_NO_ROOM;
							end else begin
								// Header byte zero now, the others from S_HDR_WR.
								mem_we        = 1'b1;
								mem_wdata     = in_len[BYTE_W-1:0];
								wp_d          = ring_next(wp_q);
								hdr_sh_d      = HDR_BITS'(in_len) >> 8;
								hcnt_d        = HCW'(1);
								arem_d        = in_len;
								push_res.last = (in_len == '0);
								if (HEADER_BYTES > 1) begin
									state_d = S_HDR_WR;
								end
							end
						end
						OP_APPEND_BYTE: begin
							push = 1'b1;
							if (arem_q == '0) begin
								push_res.status = STAT_PROTO;
							end else begin
								mem_we        = 1'b1;
								mem_wdata     = in_byte;
								wp_d          = ring_next(wp_q);
								arem_d        = arem_q - 1'b1;
								push_res.last = (arem_q == LEN_W'(1));
							end
						end
						OP_POP_START: begin
							if (rrem_q != '0) begin
								push            = 1'b1;
								push_res.status = STAT_PROTO;
							end else if (used_w < CW'(HEADER_BYTES)) begin
								push            = 1'b1;
								push_res.status = STAT_NO_MSG;
							end else begin
								mem_re  = 1'b1;
								raddr_d = ring_next(rp_q);
								hcnt_d  = '0;
								cap_d   = in_len;
								state_d = S_HDR_RD;
							end
						end
						OP_READ_BYTE: begin
							if (rrem_q == '0) begin
								push            = 1'b1;
								push_res.status = STAT_PROTO;
							end else begin
								mem_re  = 1'b1;
								rp_d    = ring_next(rp_q);
								rrem_d  = rrem_q - 1'b1;
								rlast_d = (rrem_q == LEN_W'(1));
								state_d = S_RD_WAIT;
							end
						end
						default: ;
					endcase
				end
			end
			S_HDR_WR: begin
				mem_we    = 1'b1;
				mem_wdata = hdr_sh_q[BYTE_W-1:0];
				wp_d      = ring_next(wp_q);
				hdr_sh_d  = hdr_sh_q >> 8;
				hcnt_d    = hcnt_q + 1'b1;
				if (hcnt_q == HCW'(HEADER_BYTES - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_HDR_RD: begin
				// Little-endian: each new byte enters at the top.
				body_d = (body_q >> 8) | (HDR_BITS'(rdata_q) << (HDR_BITS - 8));
				if (hcnt_q == HCW'(HEADER_BYTES - 1)) begin
					state_d = S_HDR_CHK;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = raddr_q;
					raddr_d   = ring_next(raddr_q);
					hcnt_d    = hcnt_q + 1'b1;
				end
			end
			S_HDR_CHK: begin
				push    = 1'b1;
				state_d = S_IDLE;
				if (body_w > avail_w) begin
					push_res.status = STAT_NO_MSG;
				end else if (body_w > cap_w) begin
					push_res.status = STAT_CAP_SMALL;
				end else begin
					rp_d              = raddr_q;
					rrem_d            = LEN_W'(body_q);
					push_res.body_len = LEN_W'(body_q);
					push_res.last     = (body_q == '0);
				end
			end
			S_RD_WAIT: begin
				push              = 1'b1;
				push_res.data_out = rdata_q;
				push_res.last     = rlast_q;
				state_d           = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= ring_q[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			arem_q <= '0;
			rrem_q <= '0;
		end else begin
			wp_q   <= wp_d;
			rp_q   <= rp_d;
			arem_q <= arem_d;
			rrem_q <= rrem_d;
		end
	end

	always_ff @(posedge clk) begin
		hcnt_q   <= hcnt_d;
		hdr_sh_q <= hdr_sh_d;
		body_q   <= body_d;
		raddr_q  <= raddr_d;
		cap_q    <= cap_d;
		rlast_q  <= rlast_d;
	end

	// Two-word result buffer: the output word, and a pending word behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			p_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			if (p_valid_q) begin
				m_valid_q <= 1'b1;
				p_valid_q <= push;
			end else begin
				m_valid_q <= push;
			end
		end else if (push) begin
			p_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!m_valid_q || m_tready) begin
			if (p_valid_q) begin
				m_res_q <= p_res_q;
				if (push) begin
					p_res_q <= push_res;
				end
			end else if (push) begin
				m_res_q <= push_res;
			end
		end else if (push) begin
			p_res_q <= push_res;
		end
	end

`include "length_prefixed_message_ring_assert.svh"

	`LPMR_ASSERT_NOW(a_pending_behind_output, clk, arst_n, p_valid_q, m_valid_q, "pending word without output word")
	`LPMR_ASSERT_NOW(a_ptr_range, clk, arst_n, 1'b1, (wp_q <= RING_AW'(RING_BYTES - 1)) && (rp_q <= RING_AW'(RING_BYTES - 1)), "ring pointer out of range")
	`LPMR_ASSERT_NEXT(a_append_count, clk, arst_n, accept && (in_op == OP_APPEND_BYTE) && (arem_q != '0), arem_q == $past(arem_q) - 1'b1, "append count did not step")
	`LPMR_ASSERT_NOW(a_check_after_read, clk, arst_n, state_q == S_HDR_CHK, $past(state_q) == S_HDR_RD, "header check without header read")

endmodule
